// ----- hw/rtl/lud_pkg.sv -----
// Shared types, constants and helpers for the LU factorization block.
`default_nettype none
package lud_pkg;
    localparam int MAX_ORDER = 8;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int ORD_W     = 4;
    localparam int THR_W     = 31;
    localparam int DATA_W    = 32;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SING = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic CFG_SIZE = 1'b0;
    localparam logic CFG_THR  = 1'b1;

    typedef struct packed {
        logic [2:0]  row_index;
        logic [2:0]  col_index;
        logic signed [31:0] element_value;
        logic        load_done;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic signed [31:0] lu_value;
        logic [2:0]  source_row;
        logic        sign_negative;
        logic [1:0]  status;
        logic        last_result;
    } out_item_t;

    // datapath operations requested by the controller
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_RD_A, OP_RD_B, OP_WR_A, OP_WR_B,
        OP_SWAP_PERM, OP_DIV_START, OP_MUL, OP_SUB, OP_EMIT_RD
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0] row_a;
        logic [IDX_W-1:0] row_b;
        logic             sel_lq;
    } cmd_t;

    typedef struct packed {
        logic              div_busy;
        logic [DATA_W-1:0] rd_data;
        logic [DATA_W:0]   mag;
    } sts_t;

    function automatic logic [DATA_W:0] magnitude(input logic [DATA_W-1:0] v);
        logic signed [DATA_W:0] s;
        s = {v[DATA_W-1], v};
        return s[DATA_W] ? (DATA_W+1)'(-s) : (DATA_W+1)'(s);
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [65:0] v, output logic sat);
        sat = 1'b0;
        if (v > 66'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -66'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/lud_div.sv -----
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
`default_nettype none
module lud_div (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [lud_pkg::DATA_W-1:0] num,
    input  wire logic [lud_pkg::DATA_W-1:0] den,
    output logic busy,
    output logic signed [64:0] quo
);
    import lud_pkg::*;
    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]     q_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W:0]   dm_reg;
    logic              neg_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W+1:0] trial;
    logic [DATA_W+1:0] shifted;
    logic [DATA_W:0]   num_mag;

    assign busy    = (cnt_reg != '0);
    assign num_mag = magnitude(num);
    assign shifted = {rem_reg, q_reg[NW-1]};
    assign trial   = shifted - {1'b0, dm_reg};
    assign quo     = neg_reg ? -$signed({1'b0, 64'(q_reg)}) : $signed({1'b0, 64'(q_reg)});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end
        else if (start) begin
            cnt_reg <= CW'(NW);
        end
        else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            q_reg   <= {num_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            dm_reg  <= magnitude(den);
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
        end
        else if (busy) begin
            if (!trial[DATA_W+1]) begin
                rem_reg <= trial[DATA_W:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else begin
                rem_reg <= shifted[DATA_W:0];
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/lud_datapath.sv -----
// Matrix memory, permutation, flags and arithmetic for the LU block.
`default_nettype none
module lud_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire lud_pkg::cmd_t cmd,
    input  wire lud_pkg::in_item_t in_item,
    output lud_pkg::sts_t sts,
    output logic [lud_pkg::IDX_W-1:0] perm_out,
    output logic parity,
    output logic sat_flag
);
    import lud_pkg::*;

    logic [DATA_W-1:0] mem [MAX_ORDER*MAX_ORDER];
    logic [DATA_W-1:0] rd_reg, a_reg, b_reg, lq_reg, ajj_reg;
    logic signed [63:0] prod_reg;
    logic [IDX_W-1:0] perm_reg [MAX_ORDER];
    logic parity_reg, sat_reg;
    logic div_busy, div_start;
    logic signed [64:0] quo;
    logic [DATA_W-1:0] lq_sat, sub_sat, wr_val;
    logic sat_q, sat_s;
    logic signed [63:0] prod_tr;

    assign div_start = (cmd.op == OP_DIV_START);

    lud_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (a_reg),
        .den   (ajj_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_comb begin
        // product >> FRAC_BITS truncated toward zero
        if (prod_reg < 0)
            prod_tr = -((-prod_reg) >>> FRAC_BITS);
        else
            prod_tr = prod_reg >>> FRAC_BITS;
        lq_sat  = sat32(66'(quo), sat_q);
        sub_sat = sat32(66'($signed(a_reg)) - 66'(prod_tr), sat_s);
        wr_val  = cmd.sel_lq ? lq_reg : a_reg;
    end

    always_ff @(posedge clk) begin
        unique case (cmd.op)
            OP_LOAD:   mem[cmd.addr] <= in_item.element_value;
            OP_WR_A:   mem[cmd.addr] <= wr_val;
            OP_WR_B:   mem[cmd.addr] <= b_reg;
            default:   ;
        endcase
        rd_reg <= mem[cmd.addr];
        unique case (cmd.op)
            OP_RD_A:   a_reg <= rd_reg;
            OP_RD_B:   b_reg <= rd_reg;
            OP_INIT:   ajj_reg <= rd_reg;
            OP_MUL:    prod_reg <= $signed(lq_reg) * $signed(rd_reg);
            OP_SUB:    a_reg <= sub_sat;
            OP_DIV_START: lq_reg <= lq_reg;
            default:   ;
        endcase
        if (cmd.op == OP_NONE && !div_busy && cmd.sel_lq)
            lq_reg <= lq_sat;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            parity_reg <= 1'b0;
            sat_reg    <= 1'b0;
            for (int i = 0; i < MAX_ORDER; i++)
                perm_reg[i] <= IDX_W'(i);
        end
        else begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    if (in_item.load_done)
                    begin
                        parity_reg <= 1'b0;
                        sat_reg    <= 1'b0;
                        for (int i = 0; i < MAX_ORDER; i++)
                            perm_reg[i] <= IDX_W'(i);
                    end
                end
                OP_SWAP_PERM:
                begin
                    perm_reg[cmd.row_a] <= perm_reg[cmd.row_b];
                    perm_reg[cmd.row_b] <= perm_reg[cmd.row_a];
                    parity_reg <= ~parity_reg;
                end
                OP_SUB:
                    sat_reg <= sat_reg | sat_s;
                default:
                begin
                    if (cmd.op == OP_NONE && !div_busy && cmd.sel_lq)
                        sat_reg <= sat_reg | sat_q;
                end
            endcase
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.rd_data  = rd_reg;
    assign sts.mag      = magnitude(rd_reg);
    assign perm_out     = perm_reg[cmd.row_a];
    assign parity       = parity_reg;
    assign sat_flag     = sat_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/lud_ctrl.sv -----
// Sequencer for load, pivot search, swap, divide, eliminate and emit.
`default_nettype none
module lud_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire lud_pkg::in_item_t in_item,
    input  wire logic [lud_pkg::ORD_W-1:0] size_in_use,
    input  wire logic [lud_pkg::THR_W-1:0] pivot_threshold,
    input  wire lud_pkg::sts_t sts,
    output lud_pkg::cmd_t cmd,
    output logic emit_req,
    output logic emit_fail,
    output logic emit_last,
    output logic [lud_pkg::IDX_W-1:0] emit_row,
    output logic [lud_pkg::IDX_W-1:0] emit_col,
    input  wire logic emit_full
);
    import lud_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_PS_RD, S_PS_W1, S_PS_CMP, S_SW_RA, S_SW_RB, S_SW_W1, S_SW_W2,
        S_SW_WR, S_PV_RD, S_PV_W1, S_PV_CHK, S_EL_RD, S_EL_W1, S_EL_DIV,
        S_EL_WAIT, S_EL_LQ, S_EL_WRL, S_UP_RB, S_UP_RA, S_UP_W1, S_UP_MUL,
        S_UP_SUB, S_UP_WR, S_EM_RD, S_EM_W1, S_EM_OUT, S_FAIL
    } state_t;

    state_t state_reg;
    logic [IDX_W-1:0] j_reg, i_reg, k_reg, piv_reg;
    logic [IDX_W:0]   n_reg;
    logic [DATA_W:0]  best_reg;
    logic             acc;
    logic [IDX_W-1:0] nm1;

    assign in_stall = (state_reg != S_LOAD);
    assign acc      = in_valid && !in_stall;
    assign nm1      = IDX_W'(n_reg - 1'b1);

    function automatic logic [ADDR_W-1:0] ad(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
        return {r, c};
    endfunction

    always_comb begin
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.row_a  = i_reg;
        cmd.row_b  = j_reg;
        emit_req   = 1'b0;
        emit_fail  = 1'b0;
        emit_last  = 1'b0;
        emit_row   = i_reg;
        emit_col   = k_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.addr = ad(in_item.row_index, in_item.col_index);
                if (acc)
                    cmd.op = OP_LOAD;
            end
            S_PS_RD, S_PS_W1: cmd.addr = ad(i_reg, j_reg);
            S_SW_RA:
            begin
                // permutation and parity flip once per swap
                cmd.addr  = ad(j_reg, k_reg);
                cmd.row_a = j_reg;
                cmd.row_b = piv_reg;
                if (k_reg == '0)
                    cmd.op = OP_SWAP_PERM;
            end
            S_SW_RB:
            begin
                cmd.addr = ad(piv_reg, k_reg);
                cmd.op   = OP_RD_B;
            end
            S_SW_W1:
            begin
                cmd.addr = ad(j_reg, k_reg);
                cmd.op   = OP_RD_A;
            end
            S_SW_W2:
            begin
                cmd.addr = ad(j_reg, k_reg);
                cmd.op   = OP_WR_A;
            end
            S_SW_WR:
            begin
                cmd.addr = ad(piv_reg, k_reg);
                cmd.op   = OP_WR_B;
            end
            S_PV_RD, S_PV_W1: cmd.addr = ad(j_reg, j_reg);
            S_PV_CHK:
            begin
                cmd.addr = ad(j_reg, j_reg);
                cmd.op   = OP_INIT;
            end
            S_EL_RD, S_EL_W1: cmd.addr = ad(i_reg, j_reg);
            S_EL_DIV:
            begin
                cmd.addr = ad(i_reg, j_reg);
                cmd.op   = OP_RD_A;
            end
            S_EL_WAIT:
            begin
                cmd.addr = ad(i_reg, j_reg);
                cmd.op   = sts.div_busy ? OP_NONE : OP_DIV_START;
            end
            S_EL_LQ:
            begin
                cmd.addr   = ad(i_reg, j_reg);
                cmd.sel_lq = 1'b1;
            end
            S_EL_WRL:
            begin
                cmd.addr   = ad(i_reg, j_reg);
                cmd.op     = OP_WR_A;
                cmd.sel_lq = 1'b1;
            end
            S_UP_RB:  cmd.addr = ad(j_reg, k_reg);
            S_UP_RA:
            begin
                // pivot row word is on the read data here
                cmd.addr = ad(i_reg, k_reg);
                cmd.op   = OP_MUL;
            end
            S_UP_W1:  cmd.addr = ad(i_reg, k_reg);
            S_UP_MUL:
            begin
                cmd.addr = ad(i_reg, k_reg);
                cmd.op   = OP_RD_A;
            end
            S_UP_SUB:
            begin
                cmd.addr = ad(i_reg, k_reg);
                cmd.op   = OP_SUB;
            end
            S_UP_WR:
            begin
                cmd.addr = ad(i_reg, k_reg);
                cmd.op   = OP_WR_A;
            end
            S_EM_RD, S_EM_W1: cmd.addr = ad(i_reg, k_reg);
            S_EM_OUT:
            begin
                cmd.addr  = ad(i_reg, k_reg);
                emit_req  = 1'b1;
                emit_last = (i_reg == nm1) && (k_reg == nm1);
            end
            S_FAIL:
            begin
                emit_req  = 1'b1;
                emit_fail = 1'b1;
                emit_last = 1'b1;
                emit_col  = j_reg;
            end
            default:  cmd.addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_LOAD;
            j_reg     <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            piv_reg   <= '0;
            n_reg     <= '0;
            best_reg  <= '0;
        end
        else begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (acc && in_item.load_done) begin
                        if (size_in_use == '0)
                            n_reg <= (IDX_W+1)'(1);
                        else if (size_in_use > ORD_W'(MAX_ORDER))
                            n_reg <= (IDX_W+1)'(MAX_ORDER);
                        else
                            n_reg <= (IDX_W+1)'(size_in_use);
                        j_reg <= '0;
                        i_reg <= '0;
                        k_reg <= '0;
                        if (size_in_use <= ORD_W'(1))
                            state_reg <= S_EM_RD;
                        else
                            state_reg <= S_PS_RD;
                    end
                end
                S_PS_RD:  state_reg <= S_PS_W1;
                S_PS_W1:  state_reg <= S_PS_CMP;
                S_PS_CMP:
                begin
                    if (i_reg == j_reg || sts.mag > best_reg) begin
                        best_reg <= sts.mag;
                        piv_reg  <= i_reg;
                    end
                    if (i_reg == nm1) begin
                        k_reg <= '0;
                        if ((i_reg == j_reg || sts.mag > best_reg) ? (i_reg != j_reg)
                                                                   : (piv_reg != j_reg))
                            state_reg <= S_SW_RA;
                        else
                            state_reg <= S_PV_RD;
                    end
                    else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_PS_RD;
                    end
                end
                S_SW_RA:  state_reg <= S_SW_RB;
                S_SW_RB:  state_reg <= S_SW_W1;
                S_SW_W1:  state_reg <= S_SW_W2;
                S_SW_W2:  state_reg <= S_SW_WR;
                S_SW_WR:
                begin
                    // swap loop step, after the write of the pivot row word
                    if (k_reg == nm1)
                        state_reg <= S_PV_RD;
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_SW_RA;
                    end
                end
                S_PV_RD:  state_reg <= S_PV_W1;
                S_PV_W1:  state_reg <= S_PV_CHK;
                S_PV_CHK:
                begin
                    if (sts.mag > {2'b00, pivot_threshold})
                        state_reg <= S_EL_RD;
                    else
                        state_reg <= S_FAIL;
                    i_reg <= j_reg + 1'b1;
                end
                S_EL_RD:  state_reg <= S_EL_W1;
                S_EL_W1:  state_reg <= S_EL_DIV;
                S_EL_DIV: state_reg <= S_EL_WAIT;
                S_EL_WAIT:
                begin
                    if (!sts.div_busy)
                        state_reg <= S_EL_LQ;
                end
                S_EL_LQ:
                begin
                    if (!sts.div_busy)
                        state_reg <= S_EL_WRL;
                end
                S_EL_WRL:
                begin
                    k_reg     <= j_reg + 1'b1;
                    state_reg <= S_UP_RB;
                end
                S_UP_RB:  state_reg <= S_UP_RA;
                S_UP_RA:  state_reg <= S_UP_W1;
                S_UP_W1:  state_reg <= S_UP_MUL;
                S_UP_MUL: state_reg <= S_UP_SUB;
                S_UP_SUB: state_reg <= S_UP_WR;
                S_UP_WR:
                begin
                    if (k_reg != nm1) begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_UP_RB;
                    end
                    else if (i_reg != nm1) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_EL_RD;
                    end
                    else if (j_reg + 1'b1 != nm1) begin
                        j_reg     <= j_reg + 1'b1;
                        i_reg     <= j_reg + 1'b1;
                        state_reg <= S_PS_RD;
                    end
                    else begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_EM_RD;
                    end
                end
                S_EM_RD:  state_reg <= S_EM_W1;
                S_EM_W1:  state_reg <= S_EM_OUT;
                S_EM_OUT:
                begin
                    if (!emit_full) begin
                        if (k_reg != nm1) begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_EM_RD;
                        end
                        else if (i_reg != nm1) begin
                            i_reg     <= i_reg + 1'b1;
                            k_reg     <= '0;
                            state_reg <= S_EM_RD;
                        end
                        else
                            state_reg <= S_LOAD;
                    end
                end
                S_FAIL:
                begin
                    if (!emit_full)
                        state_reg <= S_LOAD;
                end
                default:  state_reg <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/lu_decompose_partial_pivot.sv -----
// Top level of the LU factorization block with partial pivoting.
//
//  channel | signals                      | direction
//  --------+------------------------------+----------
//  input   | in_valid, in_stall, in_item  | items in
//  output  | out_valid, out_stall, out_item | items out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | writes
//
//  The item with load_done starts the run; input stalls until every
//  result has been handed to the output register. Elimination runs on
//  one shared read port of the 64-word matrix memory and a divider that
//  makes one quotient bit per cycle (48 bits). Output stalls hold the
//  emission of results. Reset is asynchronous, active low; the matrix
//  memory has no reset.
`default_nettype none
module lu_decompose_partial_pivot (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire lud_pkg::in_item_t in_item,
    output logic out_valid,
    input  wire logic out_stall,
    output lud_pkg::out_item_t out_item,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic cfg_index,
    input  wire logic [31:0] cfg_data
);
    import lud_pkg::*;

    logic [ORD_W-1:0] size_reg;
    logic [THR_W-1:0] thr_reg;
    cmd_t cmd;
    sts_t sts;
    logic [IDX_W-1:0] perm, erow, ecol;
    logic parity, satf, ereq, efail, elast, efull;
    logic out_valid_reg;
    out_item_t out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            size_reg <= ORD_W'(MAX_ORDER);
            thr_reg  <= '0;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIZE: size_reg <= cfg_data[ORD_W-1:0];
                CFG_THR:  thr_reg  <= cfg_data[THR_W-1:0];
                default:  ;
            endcase
        end
    end

    lud_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .size_in_use     (size_reg),
        .pivot_threshold (thr_reg),
        .sts             (sts),
        .cmd             (cmd),
        .emit_req        (ereq),
        .emit_fail       (efail),
        .emit_last       (elast),
        .emit_row        (erow),
        .emit_col        (ecol),
        .emit_full       (efull)
    );

    lud_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .sts      (sts),
        .perm_out (perm),
        .parity   (parity),
        .sat_flag (satf)
    );

    // output register; it is free when empty or being taken this cycle
    assign efull = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ereq && !efull)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (ereq && !efull) begin
            if (efail) begin
                out_reg.out_row       <= '0;
                out_reg.out_col       <= ecol;
                out_reg.lu_value      <= '0;
                out_reg.source_row    <= '0;
                out_reg.sign_negative <= 1'b0;
                out_reg.status        <= ST_SING;
                out_reg.last_result   <= 1'b1;
            end
            else begin
                out_reg.out_row       <= erow;
                out_reg.out_col       <= ecol;
                out_reg.lu_value      <= sts.rd_data;
                out_reg.source_row    <= perm;
                out_reg.sign_negative <= parity;
                out_reg.status        <= satf ? ST_SAT : ST_OK;
                out_reg.last_result   <= elast;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
endmodule
`default_nettype wire

// ----- bench/lu_decompose_partial_pivot_chk.sv -----
// Checker for the LU factorization block: watches the item channels and compares results.
`timescale 1ns / 100ps
module lu_decompose_partial_pivot_chk (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_stall,
    input  wire lud_pkg::in_item_t in_item,
    input  wire logic out_valid,
    input  wire logic out_stall,
    input  wire lud_pkg::out_item_t out_item,
    input  wire logic cfg_valid,
    input  wire logic cfg_ready,
    input  wire logic cfg_index,
    input  wire logic [31:0] cfg_data,
    output int errors,
    output int pending,
    output int results_seen
);
    import lud_pkg::*;

    logic [31:0] mat [0:63];
    logic [2:0]  perm [0:7];
    logic        odd_swaps;
    logic        sat_hit;
    logic [3:0]  order_reg;
    logic [30:0] thr_reg;
    out_item_t   lu_expected [$];

    function automatic longint sval(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint absval(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [31:0] clip(input longint v);
        if (v > 64'sd2147483647)
        begin
            sat_hit = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat_hit = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // returns failing column or -1
    function automatic int eliminate(input int n);
        int piv;
        longint best, m, ajj, l, prod;
        logic [31:0] t, lq;
        logic [2:0] p;
        for (int j = 0; j + 1 < n; j++)
        begin
            piv = j;
            best = absval(sval(mat[j*8+j]));
            for (int i = j + 1; i < n; i++)
            begin
                m = absval(sval(mat[i*8+j]));
                if (m > best)
                begin
                    best = m;
                    piv = i;
                end
            end
            if (piv != j)
            begin
                for (int k = 0; k < n; k++)
                begin
                    t = mat[j*8+k];
                    mat[j*8+k] = mat[piv*8+k];
                    mat[piv*8+k] = t;
                end
                p = perm[j];
                perm[j] = perm[piv];
                perm[piv] = p;
                odd_swaps = ~odd_swaps;
            end
            ajj = sval(mat[j*8+j]);
            if (!(absval(ajj) > longint'(thr_reg)))
                return j;
            for (int i = j + 1; i < n; i++)
            begin
                lq = clip((sval(mat[i*8+j]) * 65536) / ajj);
                l = sval(lq);
                mat[i*8+j] = lq;
                for (int k = j + 1; k < n; k++)
                begin
                    prod = (l * sval(mat[j*8+k])) / 65536;
                    mat[i*8+k] = clip(sval(mat[i*8+k]) - prod);
                end
            end
        end
        return -1;
    endfunction

    task automatic predict_item(input in_item_t it);
        int n, fail;
        out_item_t o;
        mat[{it.row_index, it.col_index}] = it.element_value;
        if (!it.load_done)
            return;
        n = (order_reg < 1) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
        for (int i = 0; i < 8; i++)
            perm[i] = 3'(i);
        odd_swaps = 1'b0;
        sat_hit = 1'b0;
        fail = eliminate(n);
        if (fail >= 0)
        begin
            o = '0;
            o.out_col = 3'(fail);
            o.status = ST_SING;
            o.last_result = 1'b1;
            lu_expected.push_back(o);
            return;
        end
        for (int i = 0; i < n; i++)
            for (int k = 0; k < n; k++)
            begin
                o.out_row = 3'(i);
                o.out_col = 3'(k);
                o.lu_value = mat[i*8+k];
                o.source_row = perm[i];
                o.sign_negative = odd_swaps;
                o.status = sat_hit ? ST_SAT : ST_OK;
                o.last_result = (i == n - 1) && (k == n - 1);
                lu_expected.push_back(o);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            order_reg <= 4'd8;
            thr_reg <= '0;
            errors <= 0;
            results_seen <= 0;
            lu_expected.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SIZE)
                    order_reg <= cfg_data[3:0];
                else
                    thr_reg <= cfg_data[30:0];
            end
            if (in_valid && !in_stall)
                predict_item(in_item);
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (lu_expected.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_item);
                    errors <= errors + 1;
                end
                else
                begin
                    e = lu_expected.pop_front();
                    if (e !== out_item)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    assign pending = lu_expected.size();
endmodule

// ----- bench/lu_decompose_partial_pivot_tb.sv -----
// Testbench top for the LU factorization block: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module lu_decompose_partial_pivot_tb;
    import lud_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_SIZE;
    logic [31:0] cfg_data = '0;

    int errors, pending, results_seen;
    int send_idle_pct = 0;     // sender gap chance, percent
    int recv_stall_pct = 0;    // receiver stall chance, percent
    int hold_cycles = 0;       // length of the next long receiver hold-off
    logic hold_req = 1'b0;     // toggled by the stimulus to start a hold-off
    logic hold_ack = 1'b0;
    int hold_left = 0;         // cycles left in the running hold-off
    int items_sent = 0;
    int runs = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    lu_decompose_partial_pivot dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lu_decompose_partial_pivot_chk chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    // Receiver: random stalls, or a long counted hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // One item: optional idle gaps, then hold valid until accepted.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (it.load_done)
            runs++;
    endtask

    task automatic drop_valid;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle;
        drop_valid();
        while (pending != 0)
            @(posedge clk);
        // a singular run may still be clearing internal state
        repeat (3000) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_elem(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            default: return 32'($signed($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    // Load the full n x n corner with random content, last item starts the run.
    task automatic load_matrix(input int n, input int kind);
        in_item_t it;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                it.row_index = 3'(r);
                it.col_index = 3'(c);
                it.element_value = rand_elem(kind);
                it.load_done = (r == n - 1) && (c == n - 1);
                send_item(it);
            end
    endtask

    task automatic load_diag(input int n, input logic [31:0] d, input logic [31:0] off);
        in_item_t it;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                it.row_index = 3'(r);
                it.col_index = 3'(c);
                it.element_value = (r == c) ? d : off;
                it.load_done = (r == n - 1) && (c == n - 1);
                send_item(it);
            end
    endtask

    initial
    begin
        int n;
        in_item_t it;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: order one, then order two with a swap and singular cases.
        write_reg(CFG_SIZE, 32'd1);
        write_reg(CFG_THR, 32'd0);
        it = '{3'd0, 3'd0, 32'sh8000_0000, 1'b1};
        send_item(it);
        wait_idle();
        write_reg(CFG_SIZE, 32'd2);
        it = '{3'd0, 3'd0, 32'sh0000_0001, 1'b0}; send_item(it);
        it = '{3'd0, 3'd1, 32'sh7fff_ffff, 1'b0}; send_item(it);
        it = '{3'd1, 3'd0, 32'sh8000_0000, 1'b0}; send_item(it);
        it = '{3'd1, 3'd1, 32'sh0001_0000, 1'b1}; send_item(it);  // swap
        wait_idle();
        load_diag(2, 32'd0, 32'd0);                                 // zero pivot
        wait_idle();
        write_reg(CFG_THR, 32'h7fff_ffff);                          // singular unless a pivot is 32'h8000_0000
        it = '{3'd7, 3'd7, 32'sh1234_5678, 1'b1};                   // reuse store as is
        send_item(it);
        wait_idle();
        write_reg(CFG_THR, 32'h0001_0000);
        load_diag(2, 32'h0001_0000, 32'd0);                         // pivot equals threshold
        wait_idle();
        write_reg(CFG_SIZE, 32'd0);                                 // order 0 acts as 1
        it = '{3'd0, 3'd0, 32'sh0002_0000, 1'b1}; send_item(it);
        wait_idle();
        write_reg(CFG_THR, 32'd0);
        write_reg(CFG_SIZE, 32'd15);                                // clamps to 8
        load_matrix(8, 1);
        wait_idle();

        // Long receiver hold-off while loads keep arriving.
        write_reg(CFG_SIZE, 32'd3);
        hold_cycles = 400;
        hold_req = ~hold_req;
        load_matrix(3, 1);
        load_matrix(3, 2);
        wait_idle();

        // Random runs over idling phases, mostly small orders.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 23 : 49) : 0;
            recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 23 : 0;
            repeat (3)
            begin
                n = ($urandom_range(9) == 0) ? 8 : $urandom_range(2, 4);
                wait_idle();
                write_reg(CFG_SIZE, 32'(n));
                write_reg(CFG_THR, ($urandom_range(5) == 0) ? $urandom_range(0, 32'h0004_0000)
                                                             : 32'd0);
                load_matrix(n, $urandom_range(2));
                if ($urandom_range(3) == 0)
                begin
                    // stray item at a random position, then a restart
                    it.row_index = 3'($urandom_range(7));
                    it.col_index = 3'($urandom_range(7));
                    it.element_value = $urandom();
                    it.load_done = 1'b0;
                    send_item(it);
                    it.row_index = 3'(n - 1);
                    it.col_index = 3'(n - 1);
                    it.load_done = 1'b1;
                    send_item(it);
                end
            end
        end
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (200) @(posedge clk);

        $display("Ran %0d loads over %0d factorizations, %0d results checked.",
                 items_sent, runs, results_seen);
        $display("Covered orders 0..15 setting, thresholds, swaps, saturation, singular cases.");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
